FILE: rtl/core/snp_pkg.sv
// Package for the SEI NAL packetizer: field widths, byte constants,
// register indexes and the structs passed between the core modules.
// No dependencies.
`timescale 1ns / 1ps

package snp_pkg;

  // Default payload limit and the fixed UUID length.
  localparam int MAX_PAYLOAD_DEF = 4096;
  localparam int ID_BYTES        = 16;
  localparam int CNT_W           = $clog2(ID_BYTES);

  // Fixed field widths of the channels.
  localparam int LEN_IN_W  = 13;
  localparam int BYTE_W    = 8;
  localparam int UUID_W    = 64;
  localparam int CFG_IDX_W = 2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START_CODE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UUID_UPPER      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UUID_LOWER      = 2'd2;

  // Stream bytes.
  localparam logic [BYTE_W-1:0] BYTE_ZERO   = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_ONE    = 8'h01;
  localparam logic [BYTE_W-1:0] BYTE_ESC    = 8'h03;
  localparam logic [BYTE_W-1:0] BYTE_NAL    = 8'h06;
  localparam logic [BYTE_W-1:0] BYTE_PTYPE  = 8'h05;
  localparam logic [BYTE_W-1:0] BYTE_FF     = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_TRAIL  = 8'h80;

  // Opcodes of an input item.
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // Configuration register contents.
  typedef struct packed {
    logic              start_code_mode;
    logic [UUID_W-1:0] uuid_upper;
    logic [UUID_W-1:0] uuid_lower;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              packet_done;
  } res_t;

endpackage

FILE: rtl/core/snp_in_if.sv
// Input item channel of the SEI NAL packetizer.
// Depends on snp_pkg for the field widths.
`timescale 1ns / 1ps

interface snp_in_if;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [snp_pkg::LEN_IN_W-1:0]   payload_length;
  logic [snp_pkg::BYTE_W-1:0]     payload_byte;

  modport source (output valid, output opcode, output payload_length,
                  output payload_byte, input ready);
  modport sink   (input valid, input opcode, input payload_length,
                  input payload_byte, output ready);
endinterface

FILE: rtl/core/snp_out_if.sv
// Result item channel of the SEI NAL packetizer.
// Depends on snp_pkg for the byte width.
`timescale 1ns / 1ps

interface snp_out_if;
  logic                       valid;
  logic                       ready;
  logic [snp_pkg::BYTE_W-1:0] out_byte;
  logic                       run_last;
  logic                       packet_done;

  modport source (output valid, output out_byte, output run_last,
                  output packet_done, input ready);
  modport sink   (input valid, input out_byte, input run_last,
                  input packet_done, output ready);
endinterface

FILE: rtl/core/snp_cfg_if.sv
// Configuration write channel of the SEI NAL packetizer.
// Depends on snp_pkg for the index and data widths.
`timescale 1ns / 1ps

interface snp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [snp_pkg::CFG_IDX_W-1:0] index;
  logic [snp_pkg::UUID_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/snp_cfg_regs.sv
// Configuration registers: start code mode and the two UUID halves.
// Depends on snp_pkg and snp_cfg_if.
`timescale 1ns / 1ps

module snp_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  snp_cfg_if.sink          cfg_ch,
  output snp_pkg::cfg_t    cfg
);
  import snp_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Writes are always taken.
  assign cfg_ch.ready = 1'b1;

  // Decode the register index; unknown indexes are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_START_CODE_MODE: cfg_nxt.start_code_mode = cfg_ch.data[0];
        CFG_UUID_UPPER:      cfg_nxt.uuid_upper      = cfg_ch.data;
        CFG_UUID_LOWER:      cfg_nxt.uuid_lower      = cfg_ch.data;
        default:             cfg_nxt                 = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/snp_out_reg.sv
// Output register of the packetizer: holds one result item until taken.
// Depends on snp_pkg and snp_out_if.
`timescale 1ns / 1ps

module snp_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  snp_pkg::res_t res,
  output logic          slot_free,
  snp_out_if.source     out_ch
);
  import snp_pkg::*;

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  // The slot can take a new item when empty or being drained.
  assign slot_free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.out_byte    = res_r.out_byte;
  assign out_ch.run_last    = res_r.run_last;
  assign out_ch.packet_done = res_r.packet_done;

endmodule

FILE: rtl/core/snp_seq.sv
// Byte sequencer: turns accepted items into NAL stream bytes, one per cycle while
// the output slot is free, with emulation prevention and trailer; uses snp_pkg, snp_in_if.
`timescale 1ns / 1ps

module snp_seq #(
  parameter int MAX_PAYLOAD = snp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  snp_in_if.sink        in_ch,
  input  snp_pkg::cfg_t cfg,
  input  logic          slot_free,
  output logic          emit,
  output snp_pkg::res_t res
);
  import snp_pkg::*;

  localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int SZ_RAW = $clog2(MAX_PAYLOAD + ID_BYTES + 1);
  localparam int SZ_W   = (SZ_RAW > 9) ? SZ_RAW : 9;

  // Sequencer phases.
  localparam logic [3:0] P_IDLE  = 4'd0;
  localparam logic [3:0] P_SC    = 4'd1;
  localparam logic [3:0] P_NH    = 4'd2;
  localparam logic [3:0] P_PT    = 4'd3;
  localparam logic [3:0] P_SZ    = 4'd4;
  localparam logic [3:0] P_ID    = 4'd5;
  localparam logic [3:0] P_ESC   = 4'd6;
  localparam logic [3:0] P_DATA  = 4'd7;
  localparam logic [3:0] P_TESC  = 4'd8;
  localparam logic [3:0] P_TZERO = 4'd9;
  localparam logic [3:0] P_TEND  = 4'd10;

  localparam logic [CNT_W-1:0] SC_LAST = CNT_W'(3);
  localparam logic [CNT_W-1:0] ID_LAST = CNT_W'(ID_BYTES - 1);
  localparam logic [1:0]       ZR_SAT  = 2'd2;

  logic [3:0]        phase_r, phase_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SZ_W-1:0]   sz_r, sz_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;
  logic [1:0]        zr_r, zr_nxt;
  logic              par_r, par_nxt;
  logic              inp_r, inp_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;

  logic [3:0]        ph_after;
  logic [BYTE_W-1:0] byte_v;
  logic              counted;
  logic              done_v;
  logic              trail;
  logic [CNT_W-1:0]  cnt_v;
  logic [SZ_W-1:0]   sz_v;
  logic [LEN_W-1:0]  left_v;
  logic [1:0]        zr_v;
  logic              par_v;
  logic              inp_v;
  logic [LEN_W-1:0]  len_sat;
  logic              accept;

  assign emit = (phase_r != P_IDLE) && slot_free;

  // Saturate the requested length to the payload limit.
  always_comb begin
    if (in_ch.payload_length > LEN_IN_W'(MAX_PAYLOAD)) begin
      len_sat = LEN_W'(MAX_PAYLOAD);
    end else begin
      len_sat = in_ch.payload_length[LEN_W-1:0];
    end
  end

  // Current byte and state after it is sent.
  always_comb begin
    ph_after = phase_r;
    byte_v   = BYTE_ZERO;
    counted  = 1'b0;
    done_v   = 1'b0;
    trail    = 1'b0;
    cnt_v    = cnt_r;
    sz_v     = sz_r;
    left_v   = left_r;
    zr_v     = zr_r;
    par_v    = par_r;
    inp_v    = inp_r;
    if (emit) begin
      case (phase_r)
        P_SC: begin
          byte_v = (cnt_r == SC_LAST) ? BYTE_ONE : BYTE_ZERO;
          if (cnt_r == SC_LAST) begin
            ph_after = P_NH;
            par_v    = 1'b0;
          end else begin
            cnt_v = cnt_r + CNT_W'(1);
          end
        end
        P_NH: begin
          byte_v   = BYTE_NAL;
          counted  = 1'b1;
          ph_after = P_PT;
        end
        P_PT: begin
          byte_v   = BYTE_PTYPE;
          counted  = 1'b1;
          ph_after = P_SZ;
        end
        P_SZ: begin
          counted = 1'b1;
          if (sz_r >= SZ_W'(BYTE_FF)) begin
            byte_v = BYTE_FF;
            sz_v   = sz_r - SZ_W'(BYTE_FF);
          end else begin
            byte_v   = sz_r[BYTE_W-1:0];
            ph_after = P_ID;
            cnt_v    = '0;
          end
        end
        P_ID: begin
          counted = 1'b1;
          if (cnt_r < CNT_W'(8)) begin
            byte_v = cfg.uuid_upper[8*(7-cnt_r[2:0]) +: 8];
          end else begin
            byte_v = cfg.uuid_lower[8*(7-cnt_r[2:0]) +: 8];
          end
          if (cnt_r == ID_LAST) begin
            ph_after = P_IDLE;
            trail    = (left_r == '0);
          end else begin
            cnt_v = cnt_r + CNT_W'(1);
          end
        end
        P_ESC: begin
          byte_v   = BYTE_ESC;
          counted  = 1'b1;
          zr_v     = 2'd0;
          ph_after = P_DATA;
        end
        P_DATA: begin
          byte_v  = byte_r;
          counted = 1'b1;
          if (byte_r == BYTE_ZERO) begin
            zr_v = (zr_r >= ZR_SAT) ? ZR_SAT : zr_r + 2'd1;
          end else begin
            zr_v = 2'd0;
          end
          if (left_r != '0) begin
            left_v = left_r - LEN_W'(1);
          end
          ph_after = P_IDLE;
          trail    = (left_v == '0);
        end
        P_TESC: begin
          byte_v   = BYTE_ESC;
          counted  = 1'b1;
          zr_v     = 2'd0;
          ph_after = P_TZERO;
        end
        P_TZERO: begin
          byte_v   = BYTE_ZERO;
          counted  = 1'b1;
          zr_v     = (zr_r >= ZR_SAT) ? ZR_SAT : zr_r + 2'd1;
          ph_after = P_TEND;
        end
        P_TEND: begin
          byte_v   = BYTE_TRAIL;
          counted  = 1'b1;
          done_v   = 1'b1;
          inp_v    = 1'b0;
          left_v   = '0;
          zr_v     = 2'd0;
          ph_after = P_IDLE;
        end
        default: begin
          ph_after = P_IDLE;
        end
      endcase
      if (counted) begin
        par_v = ~par_v;
      end
      // When the count is even, the trailer pads with a zero, escaped after a zero run of two.
      if (trail) begin
        if (!par_v) begin
          ph_after = (zr_v == ZR_SAT) ? P_TESC : P_TZERO;
        end else begin
          ph_after = P_TEND;
        end
      end
    end
  end

  // A new item enters while idle or when the current one sends its last byte.
  assign in_ch.ready = (phase_r == P_IDLE) || (emit && (ph_after == P_IDLE));
  assign accept      = in_ch.valid && in_ch.ready;

  // Next state: a newly accepted item sets up its first phase; data outside a packet is dropped.
  always_comb begin
    phase_nxt = ph_after;
    cnt_nxt   = cnt_v;
    sz_nxt    = sz_v;
    left_nxt  = left_v;
    zr_nxt    = zr_v;
    par_nxt   = par_v;
    inp_nxt   = inp_v;
    byte_nxt  = byte_r;
    if (accept) begin
      if (in_ch.opcode == OP_START) begin
        phase_nxt = P_SC;
        cnt_nxt   = cfg.start_code_mode ? CNT_W'(1) : CNT_W'(0);
        sz_nxt    = SZ_W'(len_sat) + SZ_W'(ID_BYTES);
        left_nxt  = len_sat;
        zr_nxt    = 2'd0;
        par_nxt   = 1'b0;
        inp_nxt   = 1'b1;
      end else if (inp_v) begin
        byte_nxt = in_ch.payload_byte;
        if ((zr_v == ZR_SAT) && (in_ch.payload_byte <= BYTE_ESC)) begin
          phase_nxt = P_ESC;
        end else begin
          phase_nxt = P_DATA;
        end
      end else begin
        phase_nxt = P_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      cnt_r   <= '0;
      sz_r    <= '0;
      left_r  <= '0;
      zr_r    <= 2'd0;
      par_r   <= 1'b0;
      inp_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      sz_r    <= sz_nxt;
      left_r  <= left_nxt;
      zr_r    <= zr_nxt;
      par_r   <= par_nxt;
      inp_r   <= inp_nxt;
    end
  end

  // Payload byte register needs no reset.
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  // Result item for the output register.
  always_comb begin
    res.out_byte    = byte_v;
    res.run_last    = (ph_after == P_IDLE);
    res.packet_done = done_v;
  end

endmodule

FILE: rtl/core/sei_nal_packetizer_unit.sv
// An accepted item sets the sequencer phase; its first result then goes to the output register.
// Throughput: one result byte per cycle while the output is not stalled; a data item sends its
// escape, byte and trailer as needed, a start item its start code, header, size and UUID.
// The next item is taken in the cycle its predecessor sends its last byte.
// Reset: synchronous, active-low rst_n clears the sequencer, registers and output valid.
// Top level of the SEI NAL packetizer; depends on snp_pkg, the channel interfaces,
// snp_cfg_regs, snp_seq and snp_out_reg.
`timescale 1ns / 1ps

module sei_nal_packetizer_unit #(
  parameter int MAX_PAYLOAD = snp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  snp_in_if.sink    in_ch,
  snp_out_if.source out_ch,
  snp_cfg_if.sink   cfg_ch
);
  import snp_pkg::*;

  cfg_t cfg;
  res_t res;
  logic emit;
  logic slot_free;

  // Configuration registers.
  snp_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Byte sequencer.
  snp_seq #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .slot_free (slot_free),
    .emit      (emit),
    .res       (res)
  );

  // Output register.
  snp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (emit),
    .res       (res),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

endmodule

FILE: sim/sei_nal_packetizer_unit_test.sv
// Self-checking testbench for sei_nal_packetizer_unit: drives start and data items,
// predicts the SEI NAL byte stream per accepted item and checks every result byte.
// Depends on snp_pkg, the snp_in_if / snp_out_if / snp_cfg_if interfaces and the RTL.
`timescale 1ns / 1ps

module sei_nal_packetizer_unit_test;
  import snp_pkg::*;

  localparam int MAX_LEN     = MAX_PAYLOAD_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 8;

  typedef struct {
    logic                opcode;
    logic [LEN_IN_W-1:0] payload_length;
    logic [BYTE_W-1:0]   payload_byte;
  } nal_item_t;

  typedef struct {
    logic [CFG_IDX_W-1:0] index;
    logic [UUID_W-1:0]    data;
  } reg_write_t;

  logic clk;
  logic rst_n;

  snp_in_if  in_ch ();
  snp_out_if out_ch ();
  snp_cfg_if cfg_ch ();

  sei_nal_packetizer_unit #(
    .MAX_PAYLOAD(MAX_LEN)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  // Stimulus queues, expected bytes and bookkeeping.
  nal_item_t  items_to_send[$];
  reg_write_t reg_writes[$];
  res_t       nal_bytes_due[$];
  nal_item_t  item_on_bus;
  reg_write_t write_on_bus;
  int         items_sent = 0;
  int         mismatches = 0;
  int         results_seen = 0;
  int         cycle_count = 0;
  int         in_gap = 0;
  int         out_stall = 0;
  bit         calm = 1'b0;
  bit         gen_open = 1'b0;

  // Shadow copy of the configuration registers.
  logic              short_code = 1'b0;
  logic [UUID_W-1:0] id_hi = '0;
  logic [UUID_W-1:0] id_lo = '0;

  // Shadow copy of the packetizer state.
  logic [LEN_IN_W-1:0] left_in_pkt = '0;
  logic [1:0]          zero_run = '0;
  logic                nal_parity = 1'b0;
  logic                pkt_open = 1'b0;

  always #6 clk = ~clk;

  // Append one predicted byte; counted bytes flip the NAL byte parity.
  function automatic void emit(logic [BYTE_W-1:0] b, bit counted, bit done);
    res_t r;
    r.out_byte    = b;
    r.run_last    = 1'b0;
    r.packet_done = done;
    nal_bytes_due.push_back(r);
    if (counted) nal_parity = ~nal_parity;
  endfunction

  // Payload and trailer bytes get an escape after two zeros when they are 3 or less.
  function automatic void emit_escaped(logic [BYTE_W-1:0] b);
    if (zero_run >= 2 && b <= BYTE_ESC) begin
      emit(BYTE_ESC, 1'b1, 1'b0);
      zero_run = 2'd0;
    end
    emit(b, 1'b1, 1'b0);
    if (b == BYTE_ZERO) zero_run = (zero_run >= 2) ? 2'd2 : zero_run + 2'd1;
    else zero_run = 2'd0;
  endfunction

  // The trailer leaves the NAL byte count even and closes the packet.
  function automatic void emit_trailer();
    if (!nal_parity) emit_escaped(BYTE_ZERO);
    emit(BYTE_TRAIL, 1'b1, 1'b1);
    pkt_open    = 1'b0;
    left_in_pkt = '0;
    zero_run    = 2'd0;
  endfunction

  // Work out the bytes that one accepted item causes.
  function automatic void predict_nal_bytes(nal_item_t it);
    int         base;
    int         len;
    logic [15:0] sz;
    res_t       tail;
    base = nal_bytes_due.size();
    if (it.opcode == OP_START) begin
      len = (it.payload_length > MAX_LEN) ? MAX_LEN : int'(it.payload_length);
      if (!short_code) emit(BYTE_ZERO, 1'b0, 1'b0);
      emit(BYTE_ZERO, 1'b0, 1'b0);
      emit(BYTE_ZERO, 1'b0, 1'b0);
      emit(BYTE_ONE, 1'b0, 1'b0);
      nal_parity = 1'b0;
      emit(BYTE_NAL, 1'b1, 1'b0);
      emit(BYTE_PTYPE, 1'b1, 1'b0);
      sz = 16'(len + ID_BYTES);
      while (sz >= 16'hFF) begin
        emit(BYTE_FF, 1'b1, 1'b0);
        sz = sz - 16'hFF;
      end
      emit(sz[7:0], 1'b1, 1'b0);
      for (int i = 0; i < 8; i++) emit(id_hi[63 - 8 * i -: 8], 1'b1, 1'b0);
      for (int i = 0; i < 8; i++) emit(id_lo[63 - 8 * i -: 8], 1'b1, 1'b0);
      zero_run    = 2'd0;
      left_in_pkt = LEN_IN_W'(len);
      pkt_open    = 1'b1;
      if (left_in_pkt == 0) emit_trailer();
    end else if (pkt_open) begin
      emit_escaped(it.payload_byte);
      if (left_in_pkt > 0) left_in_pkt = left_in_pkt - 1'b1;
      if (left_in_pkt == 0) emit_trailer();
    end
    if (nal_bytes_due.size() > base) begin
      tail = nal_bytes_due.pop_back();
      tail.run_last = 1'b1;
      nal_bytes_due.push_back(tail);
    end
  endfunction

  // Input driver: takes items from the queue, with random idle bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_nal_bytes(item_on_bus);
      if (!in_ch.valid || in_ch.ready) begin
        if (!calm && in_gap == 0 && $urandom_range(0, 11) == 0) in_gap = $urandom_range(1, 9);
        if (calm) in_gap = 0;
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (items_to_send.size() > 0) begin
          item_on_bus = items_to_send.pop_front();
          in_ch.opcode         <= item_on_bus.opcode;
          in_ch.payload_length <= item_on_bus.payload_length;
          in_ch.payload_byte   <= item_on_bus.payload_byte;
          in_ch.valid          <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Register write driver; the shadow registers follow each accepted write.
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_ch.valid <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (write_on_bus.index)
          CFG_START_CODE_MODE: short_code = write_on_bus.data[0];
          CFG_UUID_UPPER:      id_hi = write_on_bus.data;
          CFG_UUID_LOWER:      id_lo = write_on_bus.data;
          default: ;
        endcase
      end
      if (!cfg_ch.valid || cfg_ch.ready) begin
        if (reg_writes.size() > 0) begin
          write_on_bus = reg_writes.pop_front();
          cfg_ch.index <= write_on_bus.index;
          cfg_ch.data  <= write_on_bus.data;
          cfg_ch.valid <= 1'b1;
        end else begin
          cfg_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each byte with the oldest expectation and stalls at random.
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (nal_bytes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %0d: byte %02h last %0b done %0b", results_seen,
                     out_ch.out_byte, out_ch.run_last, out_ch.packet_done);
        end else begin
          want = nal_bytes_due.pop_front();
          if (out_ch.out_byte !== want.out_byte || out_ch.run_last !== want.run_last ||
              out_ch.packet_done !== want.packet_done) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected byte %02h last %0b done %0b, got %02h %0b %0b",
                       results_seen, want.out_byte, want.run_last, want.packet_done,
                       out_ch.out_byte, out_ch.run_last, out_ch.packet_done);
          end
        end
      end
      if (calm) begin
        out_ch.ready <= 1'b1;
      end else if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        out_stall = $urandom_range(0, 8);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sei_nal_packetizer_unit_test NOT OK");
      $finish;
    end
  end

  function automatic void push_item(logic op, int len, logic [BYTE_W-1:0] b, bit counted);
    nal_item_t it;
    it.opcode         = op;
    it.payload_length = LEN_IN_W'(len);
    it.payload_byte   = b;
    items_to_send.push_back(it);
    if (counted) items_sent++;
  endfunction

  // Start items carry a random payload byte, data items a random length.
  function automatic void push_start(int len);
    push_item(OP_START, len, BYTE_W'($urandom_range(0, 255)), 1'b1);
  endfunction

  function automatic void push_data(logic [BYTE_W-1:0] b);
    push_item(OP_DATA, $urandom_range(0, 8191), b, 1'b1);
  endfunction

  // Payload bytes lean toward zero and small values to provoke escapes.
  function automatic logic [BYTE_W-1:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return BYTE_ZERO;
    if (r < 6) return BYTE_W'($urandom_range(1, 3));
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [UUID_W-1:0] pick_uuid();
    logic [UUID_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: v = '0;
      1: v = '1;
      2: ;
      default: begin
        for (int i = 0; i < 8; i++)
          if ($urandom_range(0, 1)) v[8 * i +: 8] = BYTE_ZERO;
      end
    endcase
    return v;
  endfunction

  // Wait until the block has drained every expected byte and had time to settle.
  task automatic wait_idle();
    while (items_to_send.size() != 0 || in_ch.valid || reg_writes.size() != 0 ||
           cfg_ch.valid || nal_bytes_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic program_regs(logic mode, logic [UUID_W-1:0] hi, logic [UUID_W-1:0] lo);
    wait_idle();
    reg_writes.push_back('{CFG_START_CODE_MODE, UUID_W'(mode)});
    reg_writes.push_back('{CFG_UUID_UPPER, hi});
    reg_writes.push_back('{CFG_UUID_LOWER, lo});
    while (reg_writes.size() != 0 || cfg_ch.valid) @(negedge clk);
  endtask

  // One random sequence: mostly complete packets, some cut short, some stray data.
  task automatic add_random_sequence();
    int unsigned r;
    int          len;
    int          k;
    r = $urandom_range(0, 99);
    if (r < 6 && !gen_open) begin
      push_item(OP_DATA, $urandom_range(0, 8191), pick_byte(), 1'b0);
    end else if (r < 20) begin
      if ($urandom_range(0, 1)) len = $urandom_range(1, 8191);
      else len = $urandom_range(1, 20);
      k = $urandom_range(0, (len - 1 < 8) ? len - 1 : 8);
      push_start(len);
      for (int i = 0; i < k; i++) push_data(pick_byte());
      gen_open = 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 80) len = $urandom_range(0, 12);
      else if (r < 98) len = $urandom_range(13, 48);
      else len = $urandom_range(236, 262);
      push_start(len);
      for (int i = 0; i < len; i++) push_data(pick_byte());
      gen_open = 1'b0;
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_START;
    in_ch.payload_length = '0;
    in_ch.payload_byte = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_START_CODE_MODE;
    cfg_ch.data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: four-byte start code and an all-zero UUID sent unescaped.
    push_data(8'hAA);                 // data while idle is dropped
    push_start(0);                    // empty payload, trailer right after the UUID
    push_start(3);                    // two zeros before a three-byte trailer
    push_data(BYTE_ONE);
    push_data(BYTE_ZERO);
    push_data(BYTE_ZERO);
    push_start(1);                    // plain two-byte trailer
    push_data(BYTE_ZERO);

    // Three-byte start code, UUID with small bytes after zero runs.
    program_regs(1'b1, '1, 64'h0000_0003_0000_0100);
    push_start(6);
    push_data(BYTE_ZERO);
    push_data(BYTE_ZERO);
    push_data(BYTE_ZERO);
    push_data(BYTE_ZERO);
    push_data(BYTE_ESC);
    push_data(BYTE_FF);
    // Oversized lengths are clipped; each new start abandons the open packet.
    push_start(8191);
    push_data(8'h02);
    push_start(MAX_LEN + 1);
    push_start(MAX_LEN);
    push_data(BYTE_ZERO);
    push_start(239);                  // size field lands exactly on FF 00
    push_data(BYTE_ZERO);
    push_data(BYTE_ZERO);
    push_data(8'h02);
    gen_open = 1'b1;

    // Random phases, each under its own register setting; the last one runs without idling.
    for (int phase = 0; phase < 5; phase++) begin
      program_regs(phase[0], pick_uuid(), pick_uuid());
      if (phase == 4) calm = 1'b1;
      while (items_sent < 25 + 45 * (phase + 1)) add_random_sequence();
    end

    wait_idle();
    if (mismatches == 0 && nal_bytes_due.size() == 0) begin
      $display("sei_nal_packetizer_unit_test OK");
    end else begin
      $display("sei_nal_packetizer_unit_test NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/snp_pkg.sv
rtl/core/snp_in_if.sv
rtl/core/snp_out_if.sv
rtl/core/snp_cfg_if.sv
rtl/core/snp_cfg_regs.sv
rtl/core/snp_out_reg.sv
rtl/core/snp_seq.sv
rtl/core/sei_nal_packetizer_unit.sv
sim/sei_nal_packetizer_unit_test.sv
